// ----- hdl/dwpid_pkg.sv -----
// ----------------------------------------------------------------------------
// dwpid_pkg
// Shared types and constants for the two-wheel position pid core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwpid_pkg;

  // fixed field widths
  localparam int GAIN_W     = 20;
  localparam int DUTY_W     = 8;
  localparam int TOL_W      = 16;
  localparam int FRAC_BITS  = 16;
  localparam int TERM_SHIFT = 60;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  // parameter defaults
  localparam int POSITION_BITS_DEF = 24;
  localparam int SUM_BITS_DEF      = 40;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_P_RST     = 20'd32768;
  localparam logic [GAIN_W-1:0] GAIN_I_RST     = 20'd33;
  localparam logic [GAIN_W-1:0] GAIN_D_RST     = 20'd22938;
  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 8'd255;
  localparam logic [TOL_W-1:0]  TOLERANCE_RST  = 16'd16;

  // register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_DUTY_LIMIT = 3'd3,
    REG_TOLERANCE  = 3'd4
  } reg_idx_t;

  // request operation codes
  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // pipeline control handed to each wheel
  typedef struct packed {
    logic accept;
    logic start;
    logic load_b;
    logic load_c;
    logic load_d;
  } wheel_en_t;

  // sideband that travels with a request
  typedef struct packed {
    logic start;
    logic done;
  } side_t;

endpackage

// ----- hdl/dwpid_wheel.sv -----
// ----------------------------------------------------------------------------
// dwpid_wheel
// One wheel: error, saturating integral and difference at accept, then a
// pipelined multiply-add giving direction and clamped duty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwpid_wheel
  import dwpid_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int SUM_BITS      = SUM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wheel_en_t                       en,
  input  logic signed [POSITION_BITS-1:0] target,
  input  logic signed [POSITION_BITS-1:0] position,
  input  logic        [GAIN_W-1:0]        gain_p,
  input  logic        [GAIN_W-1:0]        gain_i,
  input  logic        [GAIN_W-1:0]        gain_d,
  input  logic        [DUTY_W-1:0]        duty_limit,
  input  logic        [TOL_W-1:0]         tolerance,
  output logic                            within_a,
  output logic                            fwd,
  output logic        [DUTY_W-1:0]        duty
);

  localparam int E_W    = POSITION_BITS + 1;
  localparam int D_W    = E_W + 1;
  localparam int ADD_W  = ((SUM_BITS > E_W) ? SUM_BITS : E_W) + 1;
  localparam int LO_W   = (SUM_BITS + 1) / 2;
  localparam int HI_W   = SUM_BITS - LO_W;
  localparam int PE_W   = GAIN_W + 1 + E_W;
  localparam int PDR_W  = GAIN_W + 1 + D_W;
  localparam int PD_W   = ((PE_W > PDR_W) ? PE_W : PDR_W) + 1;
  localparam int MAG_W  = GAIN_W + SUM_BITS;
  localparam int A_W    = (MAG_W > TERM_SHIFT + 1) ? MAG_W : TERM_SHIFT + 1;
  localparam int V_W    = ((A_W > PD_W) ? A_W : PD_W) + 2;
  localparam int CMP_W  = (E_W > TOL_W) ? E_W : TOL_W;

  localparam logic signed [ADD_W-1:0] SUM_MAX =
    {{(ADD_W - SUM_BITS + 1){1'b0}}, {(SUM_BITS - 1){1'b1}}};
  localparam logic signed [ADD_W-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic [A_W-1:0] TERM_LIMIT = A_W'(1) << TERM_SHIFT;

  // controller state
  logic signed [POSITION_BITS-1:0] goal_r;
  logic signed [SUM_BITS-1:0]      sum_r;
  logic signed [E_W-1:0]           last_r;

  // stage a: error, integral, difference
  logic signed [POSITION_BITS-1:0] goal_sel;
  logic signed [E_W-1:0]           err;
  logic        [E_W-1:0]           err_mag;
  logic signed [ADD_W-1:0]         sum_add;
  logic signed [ADD_W-1:0]         sum_sat;
  logic signed [SUM_BITS-1:0]      sum_nxt;
  logic signed [D_W-1:0]           deriv;
  logic                            in_band;

  always_comb begin
    goal_sel = en.start ? target : goal_r;
    err      = {goal_sel[POSITION_BITS-1], goal_sel} - {position[POSITION_BITS-1], position};
    err_mag  = err[E_W-1] ? (-err) : err;
    in_band  = CMP_W'(err_mag) <= CMP_W'(tolerance);
    sum_add  = ADD_W'(sum_r) + ADD_W'(err);
    if (sum_add > SUM_MAX) begin
      sum_sat = SUM_MAX;
    end else if (sum_add < SUM_MIN) begin
      sum_sat = SUM_MIN;
    end else begin
      sum_sat = sum_add;
    end
    sum_nxt = en.start ? '0 : sum_sat[SUM_BITS-1:0];
    deriv   = D_W'(err) - D_W'(last_r);
  end

  // state update on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r <= '0;
      sum_r  <= '0;
      last_r <= '0;
    end else if (en.accept) begin
      if (en.start) begin
        goal_r <= goal_sel;
      end
      sum_r  <= sum_nxt;
      last_r <= err;
    end
  end

  logic signed [E_W-1:0]      err_a_r;
  logic signed [SUM_BITS-1:0] sum_a_r;
  logic signed [D_W-1:0]      deriv_a_r;
  logic                       within_a_r;

  always_ff @(posedge clk) begin
    if (en.accept) begin
      err_a_r    <= err;
      sum_a_r    <= sum_nxt;
      deriv_a_r  <= deriv;
      within_a_r <= in_band;
    end
  end

  assign within_a = within_a_r;

  // stage b: products, integral magnitude split in two halves
  logic        [SUM_BITS-1:0]    sum_mag;
  logic signed [PE_W-1:0]        pe_nxt;
  logic signed [PDR_W-1:0]       pd_nxt;
  logic signed [PE_W-1:0]        pe_b_r;
  logic signed [PDR_W-1:0]       pd_b_r;
  logic        [GAIN_W+LO_W-1:0] ilo_b_r;
  logic        [GAIN_W+HI_W-1:0] ihi_b_r;
  logic                          neg_b_r;

  always_comb begin
    sum_mag = sum_a_r[SUM_BITS-1] ? (-sum_a_r) : sum_a_r;
    pe_nxt  = $signed({1'b0, gain_p}) * err_a_r;
    pd_nxt  = $signed({1'b0, gain_d}) * deriv_a_r;
  end

  always_ff @(posedge clk) begin
    if (en.load_b) begin
      pe_b_r  <= pe_nxt;
      pd_b_r  <= pd_nxt;
      ilo_b_r <= gain_i * sum_mag[LO_W-1:0];
      ihi_b_r <= gain_i * sum_mag[SUM_BITS-1:LO_W];
      neg_b_r <= sum_a_r[SUM_BITS-1];
    end
  end

  // stage c: recombine integral product, add p and d terms
  logic        [MAG_W-1:0] mag_c_r;
  logic signed [PD_W-1:0]  pepd_c_r;
  logic                    neg_c_r;

  always_ff @(posedge clk) begin
    if (en.load_c) begin
      mag_c_r  <= (MAG_W'(ihi_b_r) << LO_W) + MAG_W'(ilo_b_r);
      pepd_c_r <= PD_W'(pe_b_r) + PD_W'(pd_b_r);
      neg_c_r  <= neg_b_r;
    end
  end

  // stage d: clamp integral term, signed add
  logic        [A_W-1:0] term_mag;
  logic signed [V_W-1:0] term_s;
  logic signed [V_W-1:0] pepd_s;
  logic signed [V_W-1:0] v_nxt;
  logic signed [V_W-1:0] v_d_r;

  always_comb begin
    term_mag = (A_W'(mag_c_r) > TERM_LIMIT) ? TERM_LIMIT : A_W'(mag_c_r);
    term_s   = $signed({{(V_W - A_W){1'b0}}, term_mag});
    pepd_s   = V_W'(pepd_c_r);
    v_nxt    = neg_c_r ? (pepd_s - term_s) : (pepd_s + term_s);
  end

  always_ff @(posedge clk) begin
    if (en.load_d) begin
      v_d_r <= v_nxt;
    end
  end

  // direction and clamped duty
  logic [V_W-1:0] v_mag;
  logic [V_W-1:0] v_shift;

  always_comb begin
    v_mag   = v_d_r[V_W-1] ? (-v_d_r) : v_d_r;
    v_shift = v_mag >> FRAC_BITS;
    fwd     = !v_d_r[V_W-1] && (v_d_r != '0);
    duty    = (v_shift > V_W'(duty_limit)) ? duty_limit : v_shift[DUTY_W-1:0];
  end

endmodule

// ----- hdl/dual_wheel_position_pid_core.sv -----
// Two-wheel position pid core. A start request latches both targets, clears
// both integrals and loads the previous errors; a sample request runs the pid
// step for both wheels and returns direction and duty per wheel plus a done
// flag (both errors within tolerance, coast). Every request gives exactly one
// result through stages a, b, c, d and the result register; a new request is
// taken every cycle unless the output stalls. The rate is set by the per-wheel
// error, saturating integral and difference update, which completes in the
// accept cycle; the gain multiplies and final add run in stages b, c and d.
// ----------------------------------------------------------------------------
// dual_wheel_position_pid_core
// Top level: apb register file, request pipeline control, two wheel datapaths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_wheel_position_pid_core
  import dwpid_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int SUM_BITS      = SUM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [APB_ADDR_W-1:0]           paddr,
  input  logic [APB_DATA_W-1:0]           pwdata,
  output logic [APB_DATA_W-1:0]           prdata,
  output logic                            pready,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic signed [POSITION_BITS-1:0] in_target_left,
  input  logic signed [POSITION_BITS-1:0] in_target_right,
  input  logic signed [POSITION_BITS-1:0] in_position_left,
  input  logic signed [POSITION_BITS-1:0] in_position_right,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_left_forward,
  output logic [DUTY_W-1:0]               out_left_duty,
  output logic                            out_right_forward,
  output logic [DUTY_W-1:0]               out_right_duty,
  output logic                            out_done_res
);

  // configuration registers
  logic [GAIN_W-1:0] gain_p_r;
  logic [GAIN_W-1:0] gain_i_r;
  logic [GAIN_W-1:0] gain_d_r;
  logic [DUTY_W-1:0] duty_limit_r;
  logic [TOL_W-1:0]  tolerance_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= GAIN_P_RST;
      gain_i_r     <= GAIN_I_RST;
      gain_d_r     <= GAIN_D_RST;
      duty_limit_r <= DUTY_LIMIT_RST;
      tolerance_r  <= TOLERANCE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_P:     gain_p_r     <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:     gain_i_r     <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:     gain_d_r     <= pwdata[GAIN_W-1:0];
        REG_DUTY_LIMIT: duty_limit_r <= pwdata[DUTY_W-1:0];
        REG_TOLERANCE:  tolerance_r  <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_GAIN_P:     prdata = APB_DATA_W'(gain_p_r);
      REG_GAIN_I:     prdata = APB_DATA_W'(gain_i_r);
      REG_GAIN_D:     prdata = APB_DATA_W'(gain_d_r);
      REG_DUTY_LIMIT: prdata = APB_DATA_W'(duty_limit_r);
      REG_TOLERANCE:  prdata = APB_DATA_W'(tolerance_r);
      default:        prdata = '0;
    endcase
  end

  // pipeline occupancy and advance, each stage moves when the next has room
  logic valid_a_r, valid_b_r, valid_c_r, valid_d_r, out_valid_r;
  logic load_a, load_b, load_c, load_d, load_o;
  logic accept;

  assign load_o   = !out_valid_r || out_ready;
  assign load_d   = !valid_d_r || load_o;
  assign load_c   = !valid_c_r || load_d;
  assign load_b   = !valid_b_r || load_c;
  assign load_a   = !valid_a_r || load_b;
  assign in_ready = load_a;
  assign accept   = in_valid && load_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r   <= 1'b0;
      valid_b_r   <= 1'b0;
      valid_c_r   <= 1'b0;
      valid_d_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_a) valid_a_r   <= in_valid;
      if (load_b) valid_b_r   <= valid_a_r;
      if (load_c) valid_c_r   <= valid_b_r;
      if (load_d) valid_d_r   <= valid_c_r;
      if (load_o) out_valid_r <= valid_d_r;
    end
  end

  // wheel datapaths
  wheel_en_t        wheel_en;
  logic             within_l, within_r;
  logic             fwd_l, fwd_r;
  logic [DUTY_W-1:0] duty_l, duty_r;

  assign wheel_en = '{
    accept: accept,
    start:  (op_t'(in_operation) == OP_START),
    load_b: load_b,
    load_c: load_c,
    load_d: load_d
  };

  dwpid_wheel #(
    .POSITION_BITS (POSITION_BITS),
    .SUM_BITS      (SUM_BITS)
  ) u_wheel_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (wheel_en),
    .target     (in_target_left),
    .position   (in_position_left),
    .gain_p     (gain_p_r),
    .gain_i     (gain_i_r),
    .gain_d     (gain_d_r),
    .duty_limit (duty_limit_r),
    .tolerance  (tolerance_r),
    .within_a   (within_l),
    .fwd        (fwd_l),
    .duty       (duty_l)
  );

  dwpid_wheel #(
    .POSITION_BITS (POSITION_BITS),
    .SUM_BITS      (SUM_BITS)
  ) u_wheel_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (wheel_en),
    .target     (in_target_right),
    .position   (in_position_right),
    .gain_p     (gain_p_r),
    .gain_i     (gain_i_r),
    .gain_d     (gain_d_r),
    .duty_limit (duty_limit_r),
    .tolerance  (tolerance_r),
    .within_a   (within_r),
    .fwd        (fwd_r),
    .duty       (duty_r)
  );

  // request sideband: start flag and done, carried alongside the datapath
  logic  start_a_r;
  side_t side_b_r, side_c_r, side_d_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      start_a_r <= wheel_en.start;
    end
    if (load_b) begin
      side_b_r <= '{start: start_a_r, done: within_l && within_r};
    end
    if (load_c) begin
      side_c_r <= side_b_r;
    end
    if (load_d) begin
      side_d_r <= side_c_r;
    end
  end

  // result register, no drive on start or when done
  logic              coast;
  logic              left_fwd_r, right_fwd_r, done_r;
  logic [DUTY_W-1:0] left_duty_r, right_duty_r;

  assign coast = side_d_r.start || side_d_r.done;

  always_ff @(posedge clk) begin
    if (load_o) begin
      left_fwd_r   <= coast ? 1'b0 : fwd_l;
      left_duty_r  <= coast ? '0 : duty_l;
      right_fwd_r  <= coast ? 1'b0 : fwd_r;
      right_duty_r <= coast ? '0 : duty_r;
      done_r       <= side_d_r.done;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_forward  = left_fwd_r;
  assign out_left_duty     = left_duty_r;
  assign out_right_forward = right_fwd_r;
  assign out_right_duty    = right_duty_r;
  assign out_done_res      = done_r;

`ifndef SYNTHESIS
  // a done result never drives the motors
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |->
      (!out_left_forward && !out_right_forward &&
       (out_left_duty == '0) && (out_right_duty == '0)))
    else $error("done result carries drive");

  // duty never exceeds the programmed limit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_left_duty <= duty_limit_r) && (out_right_duty <= duty_limit_r)))
    else $error("duty above limit");

  // back-pressure only when every stage is occupied
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (valid_a_r && valid_b_r && valid_c_r && valid_d_r && out_valid_r))
    else $error("request stalled with a free stage");

  // a stalled result holds its stage d successor in place
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && valid_d_r) |=> valid_d_r)
    else $error("stage d lost under stall");
`endif

endmodule

// ----- bench/tb_dual_wheel_position_pid_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_wheel_position_pid_core
// Self-checking bench for the two-wheel position pid core. Start and encoder
// sample requests are driven with random gaps. Each accepted request feeds a
// cycle-free model of both wheel loops, and every result is compared field by
// field with the oldest predicted drive. The run covers directed corner
// requests, register extremes with readback, large integrals, long output
// stalls and random closed-loop moves toward random targets.
// ----------------------------------------------------------------------------

module tb_dual_wheel_position_pid_core
  import dwpid_pkg::*;
();

  localparam int PB            = POSITION_BITS_DEF;
  localparam int SB            = SUM_BITS_DEF;
  localparam int LONG_HOLD     = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS   = 40;
  localparam int WINDUP_SAMPLES = 40;
  localparam longint POS_MAX   = (longint'(1) <<< (PB - 1)) - 1;
  localparam longint POS_MIN   = -(longint'(1) <<< (PB - 1));

  // gain_p, gain_i, gain_d, duty_limit, tolerance
  localparam longint EXTREME_SETTINGS [7][5] = '{
    '{1048575, 1048575, 1048575, 255, 0},
    '{0, 0, 0, 0, 65535},
    '{0, 0, 0, 255, 0},
    '{1048575, 0, 0, 0, 16},
    '{1, 1, 1, 1, 1},
    '{0, 1048575, 0, 128, 100},
    '{0, 0, 1048575, 200, 8}
  };

  // one motor drive result
  typedef struct packed {
    logic              left_fwd;
    logic [DUTY_W-1:0] left_duty;
    logic              right_fwd;
    logic [DUTY_W-1:0] right_duty;
    logic              done;
  } drive_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_operation;
  logic signed [PB-1:0]   in_target_left;
  logic signed [PB-1:0]   in_target_right;
  logic signed [PB-1:0]   in_position_left;
  logic signed [PB-1:0]   in_position_right;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_left_forward;
  logic [DUTY_W-1:0]      out_left_duty;
  logic                   out_right_forward;
  logic [DUTY_W-1:0]      out_right_duty;
  logic                   out_done_res;

  dual_wheel_position_pid_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_target_left    (in_target_left),
    .in_target_right   (in_target_right),
    .in_position_left  (in_position_left),
    .in_position_right (in_position_right),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_forward  (out_left_forward),
    .out_left_duty     (out_left_duty),
    .out_right_forward (out_right_forward),
    .out_right_duty    (out_right_duty),
    .out_done_res      (out_done_res)
  );

  always #6 clk = ~clk;

  // controller model: register copies and per-wheel loop state
  longint cfg_gain_p, cfg_gain_i, cfg_gain_d, cfg_duty_limit, cfg_tolerance;
  longint goal_l, goal_r, integ_l, integ_r, prev_err_l, prev_err_r;
  drive_t expected_drive_q[$];

  int n_errors, n_reports, n_checked, n_starts, n_samples, n_arrivals, n_writes;
  int stall_cycles;
  bit in_idle_en, out_idle_en, long_hold_req;

  function automatic longint magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  // one wheel: saturating integral, difference, pid sum, direction and duty
  function automatic void wheel_pid_step(input longint err, inout longint integ,
                                         inout longint prev, output logic fwd,
                                         output logic [DUTY_W-1:0] duty);
    longint smax, smin, s, deriv, m, a, ti, v, cap;
    smax = (longint'(1) <<< (SB - 1)) - 1;
    smin = -smax - 1;
    s = integ + err;
    if (s > smax) s = smax;
    if (s < smin) s = smin;
    integ = s;
    deriv = err - prev;
    prev = err;
    // integral term is clamped before the add
    cap = longint'(1) <<< TERM_SHIFT;
    m = magnitude(s);
    if (cfg_gain_i != 0 && m > cap / cfg_gain_i) a = cap;
    else a = cfg_gain_i * m;
    ti = (s < 0) ? -a : a;
    v = cfg_gain_p * err + ti + cfg_gain_d * deriv;
    fwd = (v > 0);
    m = magnitude(v) >> FRAC_BITS;
    duty = (m > cfg_duty_limit) ? cfg_duty_limit[DUTY_W-1:0] : m[DUTY_W-1:0];
  endfunction

  function automatic drive_t predict_drive(input op_t op, input logic signed [PB-1:0] tl,
                                           input logic signed [PB-1:0] tr,
                                           input logic signed [PB-1:0] pl,
                                           input logic signed [PB-1:0] pr);
    drive_t d;
    longint el, er;
    logic lf, rf;
    logic [DUTY_W-1:0] ld, rd;
    d = '0;
    if (op == OP_START) begin
      goal_l = tl;
      goal_r = tr;
      el = goal_l - pl;
      er = goal_r - pr;
      integ_l = 0;
      integ_r = 0;
      prev_err_l = el;
      prev_err_r = er;
      d.done = (magnitude(el) <= cfg_tolerance) && (magnitude(er) <= cfg_tolerance);
    end else begin
      el = goal_l - pl;
      er = goal_r - pr;
      wheel_pid_step(el, integ_l, prev_err_l, lf, ld);
      wheel_pid_step(er, integ_r, prev_err_r, rf, rd);
      d.done = (magnitude(el) <= cfg_tolerance) && (magnitude(er) <= cfg_tolerance);
      // arrived means coast, loop state still moves on
      if (!d.done) begin
        d.left_fwd   = lf;
        d.left_duty  = ld;
        d.right_fwd  = rf;
        d.right_duty = rd;
      end
    end
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    n_errors++;
    if (n_reports < MAX_REPORTS) begin
      n_reports++;
      $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // send one request and record its predicted drive on acceptance
  task automatic send_request(input op_t op, input longint tl, input longint tr,
                              input longint pl, input longint pr);
    int gap;
    drive_t d;
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_target_left    <= tl[PB-1:0];
    in_target_right   <= tr[PB-1:0];
    in_position_left  <= pl[PB-1:0];
    in_position_right <= pr[PB-1:0];
    do @(posedge clk); while (!in_ready);
    d = predict_drive(op_t'(in_operation), in_target_left, in_target_right,
                      in_position_left, in_position_right);
    expected_drive_q.push_back(d);
    if (op == OP_START) n_starts++;
    else n_samples++;
    if (d.done) n_arrivals++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_drive_q.size() == 0);
  endtask

  // apb write followed by a readback of the same register
  task automatic write_reg(input reg_idx_t idx, input longint val);
    logic [APB_DATA_W-1:0] word, got;
    longint stored;
    word = val[APB_DATA_W-1:0];
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_GAIN_P:     begin cfg_gain_p = word[GAIN_W-1:0];     stored = cfg_gain_p;     end
      REG_GAIN_I:     begin cfg_gain_i = word[GAIN_W-1:0];     stored = cfg_gain_i;     end
      REG_GAIN_D:     begin cfg_gain_d = word[GAIN_W-1:0];     stored = cfg_gain_d;     end
      REG_DUTY_LIMIT: begin cfg_duty_limit = word[DUTY_W-1:0]; stored = cfg_duty_limit; end
      default:        begin cfg_tolerance = word[TOL_W-1:0];   stored = cfg_tolerance;  end
    endcase
    n_writes++;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== APB_DATA_W'(stored)) report_mismatch("register readback", stored, got);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input longint gp, input longint gi, input longint gd,
                            input longint dl, input longint tol);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_DUTY_LIMIT, dl);
    write_reg(REG_TOLERANCE, tol);
  endtask

  // angle picker: full range, near zero, near the rails, mid range
  function automatic longint rand_coord();
    logic signed [PB-1:0] r;
    case ($urandom_range(0, 4))
      0, 1: begin
        r = PB'($urandom);
        return r;
      end
      2: return longint'($urandom_range(0, 4000)) - 2000;
      3: begin
        if ($urandom_range(0, 1)) return POS_MAX - longint'($urandom_range(0, 50));
        return POS_MIN + longint'($urandom_range(0, 50));
      end
      default: return longint'($urandom_range(0, 1 << 17)) - (1 << 16);
    endcase
  endfunction

  function automatic longint clamp_pos(input longint x);
    if (x > POS_MAX) return POS_MAX;
    if (x < POS_MIN) return POS_MIN;
    return x;
  endfunction

  // closed-loop moves: a start, shrinking errors, then a settle inside the band;
  // a share of plain random requests mixed in
  task automatic run_moves(input int n_items);
    int sent, steps, settle;
    longint tl, tr, el, er, band;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        tl = rand_coord();
        tr = rand_coord();
        send_request(OP_START, tl, tr, rand_coord(), rand_coord());
        sent++;
        el = tl - in_position_left;
        er = tr - in_position_right;
        steps = $urandom_range(3, 20);
        for (int k = 0; k < steps; k++) begin
          el = el * longint'($urandom_range(20, 95)) / 100 + longint'($urandom_range(0, 40)) - 20;
          er = er * longint'($urandom_range(20, 95)) / 100 + longint'($urandom_range(0, 40)) - 20;
          send_request(OP_SAMPLE, rand_coord(), rand_coord(), clamp_pos(tl - el),
                       clamp_pos(tr - er));
          sent++;
        end
        band = (cfg_tolerance > 5000) ? 5000 : cfg_tolerance;
        settle = $urandom_range(1, 3);
        repeat (settle) begin
          el = longint'($urandom_range(0, int'(2 * band))) - band;
          er = longint'($urandom_range(0, int'(2 * band))) - band;
          send_request(OP_SAMPLE, rand_coord(), rand_coord(), clamp_pos(tl - el),
                       clamp_pos(tr - er));
          sent++;
        end
      end else begin
        send_request(op_t'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord());
        sent++;
      end
    end
  endtask

  // result sink: random stall bursts, or one long hold-off on request
  initial begin : result_sink
    int burst;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (out_idle_en && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 10);
        out_ready <= 1'b0;
        repeat (burst) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result check and stall watchdog
  always @(posedge clk) begin : result_check
    drive_t want;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready) begin
        n_checked++;
        stall_cycles = 0;
        if (expected_drive_q.size() == 0) begin
          report_mismatch("result with none pending, done_res", 'x, out_done_res);
        end else begin
          want = expected_drive_q.pop_front();
          if (out_left_forward !== want.left_fwd)
            report_mismatch("left_forward", want.left_fwd, out_left_forward);
          if (out_left_duty !== want.left_duty)
            report_mismatch("left_duty", want.left_duty, out_left_duty);
          if (out_right_forward !== want.right_fwd)
            report_mismatch("right_forward", want.right_fwd, out_right_forward);
          if (out_right_duty !== want.right_duty)
            report_mismatch("right_duty", want.right_duty, out_right_duty);
          if (out_done_res !== want.done)
            report_mismatch("done_res", want.done, out_done_res);
        end
      end else if (in_valid && in_ready) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t no request or result moved for %0d cycles, %0d results pending",
                   $time, stall_cycles, expected_drive_q.size());
          $display("dual_wheel_position_pid_core regression: fail");
          $finish;
        end
      end
    end
  end

  // corner requests at reset settings
  task automatic test_directed_cases();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    // samples before any start run against zero goals
    send_request(OP_SAMPLE, 0, 0, 1000, -1000);
    send_request(OP_SAMPLE, POS_MAX, POS_MIN, POS_MIN, POS_MAX);
    // arrived on a sample, integrals keep moving
    send_request(OP_SAMPLE, 0, 0, 5, -3);
    // start on the edge of the band, then just outside
    send_request(OP_START, 500, -500, 516, -484);
    send_request(OP_START, 500, -500, 483, -500);
    // largest errors both ways
    send_request(OP_START, POS_MAX, POS_MIN, POS_MIN, POS_MAX);
    send_request(OP_SAMPLE, 0, 0, POS_MIN, POS_MAX);
    send_request(OP_SAMPLE, 0, 0, POS_MIN + 100, POS_MAX - 100);
    send_request(OP_SAMPLE, 0, 0, POS_MAX, POS_MIN);
    send_request(OP_SAMPLE, 0, 0, POS_MAX - 40, POS_MIN + 40);
    // zero goal, errors around the tolerance edge
    send_request(OP_START, 0, 0, 0, 0);
    send_request(OP_SAMPLE, -1, -1, -17, 17);
    send_request(OP_SAMPLE, 0, 0, 16, -16);
    send_request(OP_SAMPLE, 0, 0, 1, 0);
    // one wheel arrives first, then overshoot
    send_request(OP_START, 2000, 2000, 0, 1995);
    send_request(OP_SAMPLE, 0, 0, 1998, 0);
    send_request(OP_SAMPLE, 0, 0, 2000, 2000);
    send_request(OP_SAMPLE, 0, 0, 2100, 1900);
    send_request(OP_SAMPLE, 0, 0, 2000, 2017);
  endtask

  task automatic test_register_extremes();
    for (int i = 0; i < 7; i++) begin
      set_config(EXTREME_SETTINGS[i][0], EXTREME_SETTINGS[i][1], EXTREME_SETTINGS[i][2],
                 EXTREME_SETTINGS[i][3], EXTREME_SETTINGS[i][4]);
      in_idle_en  = $urandom_range(0, 1);
      out_idle_en = $urandom_range(0, 1);
      run_moves(30);
    end
  endtask

  // pile up both integrals with the largest errors at full rate, then ease off
  task automatic test_integral_windup();
    set_config(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, DUTY_LIMIT_RST, TOLERANCE_RST);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    send_request(OP_START, POS_MAX, POS_MIN, POS_MIN, POS_MAX);
    repeat (WINDUP_SAMPLES) send_request(OP_SAMPLE, 0, 0, POS_MIN, POS_MAX);
    send_request(OP_SAMPLE, 0, 0, POS_MAX - 1000, POS_MIN + 1000);
    send_request(OP_SAMPLE, 0, 0, POS_MAX, POS_MIN);
    send_request(OP_SAMPLE, 0, 0, POS_MAX - 5, POS_MIN + 7);
  endtask

  // sink holds off while requests keep coming, so the core fills and stalls
  task automatic test_output_backpressure();
    in_idle_en    = 1'b0;
    out_idle_en   = 1'b0;
    long_hold_req = 1'b1;
    run_moves(60);
  endtask

  // sender stops until every pending result is back
  task automatic test_drain_pause();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    repeat (4) begin
      run_moves(25);
      wait_drained();
    end
  endtask

  task automatic test_random_settings();
    longint gp, gi, gd, dl, tol;
    repeat (5) begin
      gp  = $urandom_range(0, 1) ? $urandom_range(0, 1048575) : $urandom_range(0, 1 << 17);
      gi  = $urandom_range(0, 3) ? $urandom_range(0, 200) : $urandom_range(0, 1048575);
      gd  = $urandom_range(0, 1) ? $urandom_range(0, 1048575) : $urandom_range(0, 1 << 16);
      dl  = $urandom_range(0, 255);
      tol = $urandom_range(0, 3) ? $urandom_range(0, 64) : $urandom_range(0, 65535);
      set_config(gp, gi, gd, dl, tol);
      in_idle_en  = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      run_moves(100);
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    set_config(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, DUTY_LIMIT_RST, TOLERANCE_RST);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    run_moves(200);
  endtask

  initial begin : regression
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_valid          = 1'b0;
    in_operation      = OP_START;
    in_target_left    = '0;
    in_target_right   = '0;
    in_position_left  = '0;
    in_position_right = '0;
    in_idle_en        = 1'b0;
    out_idle_en       = 1'b0;
    long_hold_req     = 1'b0;
    cfg_gain_p        = GAIN_P_RST;
    cfg_gain_i        = GAIN_I_RST;
    cfg_gain_d        = GAIN_D_RST;
    cfg_duty_limit    = DUTY_LIMIT_RST;
    cfg_tolerance     = TOLERANCE_RST;
    goal_l            = 0;
    goal_r            = 0;
    integ_l           = 0;
    integ_r           = 0;
    prev_err_l        = 0;
    prev_err_r        = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_register_extremes();
    test_integral_windup();
    test_output_backpressure();
    test_drain_pause();
    test_random_settings();
    test_full_rate();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d starts and %0d samples (%0d arrivals), %0d register writes",
             n_starts, n_samples, n_arrivals, n_writes);
    $display("%0d results checked against the model, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("dual_wheel_position_pid_core regression: pass");
    end else begin
      $display("dual_wheel_position_pid_core regression: fail");
    end
    $finish;
  end

endmodule
